/* rtl/ctwa_pkg.sv */
`default_nettype none

package ctwa_pkg;

  // Width of the CORDIC x/y datapath: vectors are scaled to a 2^40 full scale,
  // gain and pre-rotation grow them to under 2^42
  localparam int XW = 44;
  // Q24 angle width: covers the difference of two directions
  localparam int ZW = 28;
  // Q16 angle width after rounding
  localparam int AW = ZW - 8;
  // Coordinates are scaled so that their full scale lands on this bit
  localparam int SCALE_POS = 40;
  localparam int MAX_STAGES = 24;

  localparam logic signed [ZW-1:0] PI_Q24      = ZW'(52707179);
  localparam logic signed [ZW-1:0] HALF_PI_Q24 = ZW'(26353589);
  localparam logic signed [ZW-1:0] TWO_PI_Q24  = ZW'(105414358);
  localparam logic signed [ZW-1:0] RND_Q24     = ZW'(128);
  localparam logic signed [AW-1:0] ANG_MAX_Q16 = AW'(205887);

  localparam logic signed [ZW-1:0] ATAN_Q24 [MAX_STAGES] = '{
    ZW'(13176795), ZW'(7778716), ZW'(4110060), ZW'(2086331), ZW'(1047214),
    ZW'(524117), ZW'(262123), ZW'(131069), ZW'(65536), ZW'(32768),
    ZW'(16384), ZW'(8192), ZW'(4096), ZW'(2048), ZW'(1024), ZW'(512),
    ZW'(256), ZW'(128), ZW'(64), ZW'(32), ZW'(16), ZW'(8), ZW'(4), ZW'(2)
  };

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic zero;
  } ctwa_tag_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } ctwa_vec_t;

endpackage

`default_nettype wire

/* rtl/ctwa_prep.sv */
`default_nettype none

module ctwa_prep import ctwa_pkg::*; #(
  parameter int COORD_BITS = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         advance_i,
  input  logic                         valid_i,
  input  logic signed [COORD_BITS-1:0] strand_a_x_i,
  input  logic signed [COORD_BITS-1:0] strand_a_y_i,
  input  logic signed [COORD_BITS-1:0] strand_b_x_i,
  input  logic signed [COORD_BITS-1:0] strand_b_y_i,
  input  logic                         first_step_i,
  input  logic                         last_step_i,
  output ctwa_tag_t                    tag_o,
  output ctwa_vec_t                    vec_o
);

  localparam int SHIFT = SCALE_POS - COORD_BITS;

  logic signed [COORD_BITS:0] dx, dy;
  logic signed [XW-1:0]       sx, sy;
  ctwa_vec_t                  vec_d;
  ctwa_tag_t                  tag_q;
  ctwa_vec_t                  vec_q;

  assign dx = (COORD_BITS+1)'(strand_b_x_i) - (COORD_BITS+1)'(strand_a_x_i);
  assign dy = (COORD_BITS+1)'(strand_b_y_i) - (COORD_BITS+1)'(strand_a_y_i);
  assign sx = XW'(dx) <<< SHIFT;
  assign sy = XW'(dy) <<< SHIFT;

  // Rotate the left half plane by a quarter turn so the chain converges
  always_comb begin
    vec_d.x = sx;
    vec_d.y = sy;
    vec_d.z = '0;
    if (sx < 0) begin
      if (sy >= 0) begin
        vec_d.x = sy;
        vec_d.y = -sx;
        vec_d.z = HALF_PI_Q24;
      end else begin
        vec_d.x = -sy;
        vec_d.y = sx;
        vec_d.z = -HALF_PI_Q24;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (advance_i) begin
      tag_q.valid <= valid_i;
      tag_q.first <= first_step_i;
      tag_q.last  <= last_step_i;
      tag_q.zero  <= (dx == '0) && (dy == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      vec_q <= vec_d;
    end
  end

  assign tag_o = tag_q;
  assign vec_o = vec_q;

endmodule

`default_nettype wire

/* rtl/ctwa_cell.sv */
`default_nettype none

module ctwa_cell import ctwa_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      advance_i,
  input  ctwa_tag_t tag_i,
  input  ctwa_vec_t vec_i,
  output ctwa_tag_t tag_o,
  output ctwa_vec_t vec_o
);

  ctwa_vec_t vec_d;
  ctwa_tag_t tag_q;
  ctwa_vec_t vec_q;

  // Rotate toward the x axis by the angle of this stage
  always_comb begin
    if (vec_i.y > 0) begin
      vec_d.x = vec_i.x + (vec_i.y >>> STAGE);
      vec_d.y = vec_i.y - (vec_i.x >>> STAGE);
      vec_d.z = vec_i.z + ATAN_Q24[STAGE];
    end else begin
      vec_d.x = vec_i.x - (vec_i.y >>> STAGE);
      vec_d.y = vec_i.y + (vec_i.x >>> STAGE);
      vec_d.z = vec_i.z - ATAN_Q24[STAGE];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (advance_i) begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      vec_q <= vec_d;
    end
  end

  assign tag_o = tag_q;
  assign vec_o = vec_q;

endmodule

`default_nettype wire

/* rtl/ctwa_accum.sv */
`default_nettype none

module ctwa_accum import ctwa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctwa_tag_t            tag_i,
  input  logic signed [ZW-1:0] z_i,
  input  logic                 out_stall_i,
  output logic                 advance_o,
  output logic                 out_valid_o,
  output logic signed [31:0]   twist_sum_o,
  output logic                 saturated_o
);

  // Angle stage
  logic signed [ZW-1:0] prev_z_q;
  logic                 prev_zero_q;
  logic                 have_q;
  logic signed [ZW-1:0] diff, wrapped, rounded;
  logic                 a_valid_q, a_first_q, a_last_q, a_contrib_q;
  logic signed [AW-1:0] a_ang_q;

  // Sum stage
  logic signed [31:0]   run_q;
  logic                 clip_q;
  logic signed [31:0]   base;
  logic signed [32:0]   sum_wide;
  logic signed [31:0]   run_d;
  logic                 clip_d;
  logic                 out_valid_q;
  logic signed [31:0]   out_sum_q;
  logic                 out_sat_q;

  // Hold the whole chain only when the closing beat meets a full result register
  assign advance_o = !(out_valid_q && out_stall_i && a_valid_q && a_last_q);

  assign diff = z_i - prev_z_q;

  always_comb begin
    priority if (diff > PI_Q24) begin
      wrapped = diff - TWO_PI_Q24;
    end else if (diff <= -PI_Q24) begin
      wrapped = diff + TWO_PI_Q24;
    end else begin
      wrapped = diff;
    end
  end

  assign rounded = wrapped + RND_Q24;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      have_q    <= 1'b0;
    end else if (advance_o) begin
      a_valid_q <= tag_i.valid;
      if (tag_i.valid) begin
        have_q <= !tag_i.last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && tag_i.valid) begin
      prev_z_q    <= z_i;
      prev_zero_q <= tag_i.zero;
      a_first_q   <= tag_i.first;
      a_last_q    <= tag_i.last;
      a_contrib_q <= have_q && !tag_i.first && !tag_i.zero && !prev_zero_q;
      a_ang_q     <= rounded[ZW-1:8];
    end
  end

  assign base     = a_first_q ? '0 : run_q;
  assign sum_wide = 33'(base) + 33'(a_ang_q);

  always_comb begin
    run_d  = base;
    clip_d = a_first_q ? 1'b0 : clip_q;
    if (a_contrib_q) begin
      if (sum_wide[32] != sum_wide[31]) begin
        run_d  = sum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        clip_d = 1'b1;
      end else begin
        run_d = sum_wide[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance_o && a_valid_q) begin
        if (a_last_q) begin
          run_q  <= '0;
          clip_q <= 1'b0;
        end else begin
          run_q  <= run_d;
          clip_q <= clip_d;
        end
      end
      if (advance_o && a_valid_q && a_last_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && a_valid_q && a_last_q) begin
      out_sum_q <= run_d;
      out_sat_q <= clip_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign twist_sum_o = out_sum_q;
  assign saturated_o = out_sat_q;

`ifndef SYNTHESIS
  a_close_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && a_valid_q && a_last_q |=> out_valid_q)
    else $error("closing beat did not load the result register");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && a_valid_q && a_last_q |=> run_q == '0 && !clip_q)
    else $error("sum not cleared after frame end");

  a_ang_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && a_contrib_q |-> a_ang_q <= ANG_MAX_Q16 && a_ang_q >= -ANG_MAX_Q16)
    else $error("wrapped angle outside half turn");

  a_clip_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && a_valid_q && !a_first_q && !a_last_q && clip_q |=> clip_q)
    else $error("clip flag dropped inside a frame");
`endif

endmodule

`default_nettype wire

/* rtl/cumulative_twist_accumulator_top.sv */
`default_nettype none

// Cumulative twist accumulator. Each beat carries one base pair (strand A and
// strand B atom x/y); the block turns the pair vector into a direction with a
// chain of CORDIC_STAGES (at most MAX_STAGES) vectoring cells, takes the
// wrapped difference to the previous pair's direction and adds it, rounded to
// Q16 radians, into a saturating 32-bit sum. The sum and a clip flag leave on
// the frame's last beat; first_step restarts the sum. One beat is taken every
// cycle unless stalled; a closing beat passes the prep register, the cell
// registers and the angle stage to the output register. Input stalls only
// while a result waits unread in the output register and the next closing
// beat is in the angle stage. Zero-length vectors contribute no angle.
module cumulative_twist_accumulator_top import ctwa_pkg::*; #(
  parameter int CORDIC_STAGES = 16,
  parameter int COORD_BITS    = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] strand_a_x_i,
  input  logic signed [COORD_BITS-1:0] strand_a_y_i,
  input  logic signed [COORD_BITS-1:0] strand_b_x_i,
  input  logic signed [COORD_BITS-1:0] strand_b_y_i,
  input  logic                         first_step_i,
  input  logic                         last_step_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [31:0]           twist_sum_o,
  output logic                         saturated_o
);

  localparam int NS = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

  logic      advance;
  ctwa_tag_t tag [NS+1];
  ctwa_vec_t vec [NS+1];

  assign in_stall_o = !advance;

  ctwa_prep #(
    .COORD_BITS(COORD_BITS)
  ) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .valid_i     (in_valid_i),
    .strand_a_x_i(strand_a_x_i),
    .strand_a_y_i(strand_a_y_i),
    .strand_b_x_i(strand_b_x_i),
    .strand_b_y_i(strand_b_y_i),
    .first_step_i(first_step_i),
    .last_step_i (last_step_i),
    .tag_o       (tag[0]),
    .vec_o       (vec[0])
  );

  for (genvar g = 0; g < NS; g++) begin : g_cell
    ctwa_cell #(
      .STAGE(g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .advance_i(advance),
      .tag_i    (tag[g]),
      .vec_i    (vec[g]),
      .tag_o    (tag[g+1]),
      .vec_o    (vec[g+1])
    );
  end

  ctwa_accum u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tag_i      (tag[NS]),
    .z_i        (vec[NS].z),
    .out_stall_i(out_stall_i),
    .advance_o  (advance),
    .out_valid_o(out_valid_o),
    .twist_sum_o(twist_sum_o),
    .saturated_o(saturated_o)
  );

endmodule

`default_nettype wire

/* dv/twist_checker.sv */
`default_nettype none

module twist_checker #(
  parameter int CORDIC_STAGES = 16,
  parameter int COORD_BITS    = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic signed [COORD_BITS-1:0] strand_a_x_i,
  input  logic signed [COORD_BITS-1:0] strand_a_y_i,
  input  logic signed [COORD_BITS-1:0] strand_b_x_i,
  input  logic signed [COORD_BITS-1:0] strand_b_y_i,
  input  logic                         first_step_i,
  input  logic                         last_step_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic signed [31:0]           twist_sum_i,
  input  logic                         saturated_i,
  output int                           pending_o,
  output int                           fail_count_o
);

  localparam longint PI_Q24      = 52707179;
  localparam longint HALF_PI_Q24 = 26353589;
  localparam longint SUM_MAX     = 64'sd2147483647;
  localparam longint SUM_MIN     = -64'sd2147483648;
  localparam int     STAGE_CAP   = 24;

  localparam longint ATAN_TABLE [STAGE_CAP] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117,
    262123, 131069, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128,
    64, 32, 16, 8, 4, 2
  };

  typedef struct packed {
    logic signed [31:0] sum;
    logic               clip;
  } frame_result_t;

  frame_result_t frame_results_q [$];

  longint prev_dx;
  longint prev_dy;
  bit     have_prev;
  int     twist_acc;
  bit     clip_flag;

  // Vectoring CORDIC: direction of (vx, vy) in Q24 radians.
  function automatic longint heading_q24(longint vx, longint vy);
    longint px, py, ang, nx, ny, t;
    int     n;
    px  = vx * (64'sd1 << (40 - COORD_BITS));
    py  = vy * (64'sd1 << (40 - COORD_BITS));
    ang = 0;
    // fold the left half plane onto the right one first
    if (px < 0) begin
      t = px;
      if (py >= 0) begin
        px  = py;
        py  = -t;
        ang = HALF_PI_Q24;
      end else begin
        px  = -py;
        py  = t;
        ang = -HALF_PI_Q24;
      end
    end
    n = (CORDIC_STAGES > STAGE_CAP) ? STAGE_CAP : CORDIC_STAGES;
    for (int i = 0; i < n; i++) begin
      if (py > 0) begin
        nx  = px + (py >>> i);
        ny  = py - (px >>> i);
        ang = ang + ATAN_TABLE[i];
      end else begin
        nx  = px - (py >>> i);
        ny  = py + (px >>> i);
        ang = ang - ATAN_TABLE[i];
      end
      px = nx;
      py = ny;
    end
    return ang;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  task automatic take_pair();
    longint        dx, dy, diff, step, total;
    frame_result_t res;
    dx = longint'(strand_b_x_i) - longint'(strand_a_x_i);
    dy = longint'(strand_b_y_i) - longint'(strand_a_y_i);
    if (first_step_i) begin
      have_prev = 1'b0;
      twist_acc = 0;
      clip_flag = 1'b0;
    end
    if (have_prev && !(dx == 0 && dy == 0) && !(prev_dx == 0 && prev_dy == 0)) begin
      diff = heading_q24(dx, dy) - heading_q24(prev_dx, prev_dy);
      if (diff > PI_Q24) diff = diff - 2 * PI_Q24;
      if (diff <= -PI_Q24) diff = diff + 2 * PI_Q24;
      step  = (diff + 128) >>> 8;
      total = longint'(twist_acc) + step;
      if (total > SUM_MAX) begin
        total     = SUM_MAX;
        clip_flag = 1'b1;
      end
      if (total < SUM_MIN) begin
        total     = SUM_MIN;
        clip_flag = 1'b1;
      end
      twist_acc = int'(total);
    end
    prev_dx   = dx;
    prev_dy   = dy;
    have_prev = 1'b1;
    if (last_step_i) begin
      res.sum  = twist_acc;
      res.clip = clip_flag;
      frame_results_q.push_back(res);
      have_prev = 1'b0;
      twist_acc = 0;
      clip_flag = 1'b0;
    end
  endtask

  task automatic check_result();
    frame_result_t want;
    if (frame_results_q.size() == 0) begin
      report("result with no frame closed", longint'(twist_sum_i), 0);
    end else begin
      want = frame_results_q.pop_front();
      if (twist_sum_i !== want.sum) begin
        report("twist_sum differs", longint'(twist_sum_i), longint'(want.sum));
      end
      if (saturated_i !== want.clip) begin
        report("saturated differs", longint'(saturated_i), longint'(want.clip));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_results_q.delete();
      prev_dx      = 0;
      prev_dy      = 0;
      have_prev    = 1'b0;
      twist_acc    = 0;
      clip_flag    = 1'b0;
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) take_pair();
      if (out_valid_i && !out_stall_i) check_result();
      pending_o = frame_results_q.size();
    end
  end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`default_nettype none

module tb_top;

  localparam int CORDIC_STAGES = 16;
  localparam int COORD_BITS    = 20;
  localparam int CYCLE_LIMIT   = 40000;
  localparam int RANDOM_PAIRS  = 1430;
  localparam int SPIN_PAIRS    = 120;

  localparam int CMIN = -(2 ** (COORD_BITS - 1));
  localparam int CMAX = (2 ** (COORD_BITS - 1)) - 1;

  // unit steps of the eight compass directions, counterclockwise from +x
  localparam int DIR_X [8] = '{1, 1, 0, -1, -1, -1, 0, 1};
  localparam int DIR_Y [8] = '{0, 1, 1, 1, 0, -1, -1, -1};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                         in_valid   = 1'b0;
  logic                         in_stall;
  logic signed [COORD_BITS-1:0] strand_a_x = '0;
  logic signed [COORD_BITS-1:0] strand_a_y = '0;
  logic signed [COORD_BITS-1:0] strand_b_x = '0;
  logic signed [COORD_BITS-1:0] strand_b_y = '0;
  logic                         first_step = 1'b0;
  logic                         last_step  = 1'b0;
  logic                         out_valid;
  logic                         out_stall  = 1'b0;
  logic signed [31:0]           twist_sum;
  logic                         saturated;

  int pending;
  int fail_count;
  int cycle_count = 0;
  bit steady      = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  cumulative_twist_accumulator_top #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .COORD_BITS   (COORD_BITS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .strand_a_x_i(strand_a_x),
    .strand_a_y_i(strand_a_y),
    .strand_b_x_i(strand_b_x),
    .strand_b_y_i(strand_b_y),
    .first_step_i(first_step),
    .last_step_i (last_step),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .twist_sum_o (twist_sum),
    .saturated_o (saturated)
  );

  twist_checker #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .COORD_BITS   (COORD_BITS)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .strand_a_x_i(strand_a_x),
    .strand_a_y_i(strand_a_y),
    .strand_b_x_i(strand_b_x),
    .strand_b_y_i(strand_b_y),
    .first_step_i(first_step),
    .last_step_i (last_step),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .twist_sum_i (twist_sum),
    .saturated_i (saturated),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  always @(posedge clk_i) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 8);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Drive one base pair and hold it until the beat is taken.
  task automatic send_pair(input int ax, ay, bx, by, input bit first, last);
    while (!steady && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    strand_a_x <= COORD_BITS'(ax);
    strand_a_y <= COORD_BITS'(ay);
    strand_b_x <= COORD_BITS'(bx);
    strand_b_y <= COORD_BITS'(by);
    first_step <= first;
    last_step  <= last;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  function automatic int pick_coord();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return CMIN;
      1: return CMAX;
      2: return 0;
      3, 4: return int'($urandom_range(0, 200)) - 100;
      default: return int'(signed'(COORD_BITS'($urandom)));
    endcase
  endfunction

  // Turn the pair vector by dir_step eighths of a turn per beat, then back
  // for back_steps beats; long enough runs drive the sum into its limit.
  task automatic spin_frame(int count, int dir_step, int back_steps);
    int dir, r, ox, oy, total;
    dir   = 0;
    total = count + back_steps;
    for (int k = 0; k < total; k++) begin
      r  = int'($urandom_range(1000, 200000));
      ox = int'($urandom_range(0, 400000)) - 200000;
      oy = int'($urandom_range(0, 400000)) - 200000;
      send_pair(ox, oy, ox + DIR_X[dir] * r, oy + DIR_Y[dir] * r, k == 0, k == total - 1);
      dir = (dir + ((k < count) ? dir_step : -dir_step) + 8) % 8;
    end
  endtask

  initial begin
    int sent, len;
    bit noisy;
    int ax, ay;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lone pair opens and closes its frame
    send_pair(CMIN, CMAX, CMAX, CMIN, 1'b1, 1'b1);
    // widest vectors, half turns, then axis and zero vectors
    send_pair(CMIN, CMIN, CMAX, CMAX, 1'b1, 1'b0);
    send_pair(CMAX, CMAX, CMIN, CMIN, 1'b0, 1'b0);
    send_pair(CMAX, CMIN, CMIN, CMAX, 1'b0, 1'b0);
    send_pair(CMIN, CMAX, CMAX, CMIN, 1'b0, 1'b0);
    send_pair(0, 0, 0, 0, 1'b0, 1'b0);
    send_pair(5, 5, 5, 5, 1'b0, 1'b0);
    send_pair(0, 0, -300, 0, 1'b0, 1'b0);
    send_pair(0, 0, -300, -1, 1'b0, 1'b0);
    send_pair(0, 0, 0, 300, 1'b0, 1'b0);
    send_pair(0, 0, 0, -300, 1'b0, 1'b0);
    send_pair(0, 0, 300, 0, 1'b0, 1'b1);
    // zero vector opens the frame
    send_pair(7, 7, 7, 7, 1'b1, 1'b0);
    send_pair(0, 0, 1, 0, 1'b0, 1'b0);
    send_pair(0, 0, 0, 1, 1'b0, 1'b1);
    // no first_step: the frame starts right after the previous close
    send_pair(100, 0, 0, 0, 1'b0, 1'b0);
    send_pair(0, 100, 0, 0, 1'b0, 1'b0);
    send_pair(0, 0, 100, 0, 1'b0, 1'b1);
    // exact half turn on unit vectors
    send_pair(0, 0, 1, 0, 1'b1, 1'b0);
    send_pair(0, 0, -1, 0, 1'b0, 1'b1);
    // first_step in mid-frame restarts the sum
    send_pair(0, 0, 1, 1, 1'b0, 1'b0);
    send_pair(0, 0, -1, 1, 1'b1, 1'b0);
    send_pair(0, 0, -1, -1, 1'b0, 1'b1);

    // spin both ways, no idling on either side
    steady = 1'b1;
    spin_frame(SPIN_PAIRS, 3, 10);
    spin_frame(SPIN_PAIRS, -3, 0);
    steady = 1'b0;

    sent = 0;
    while (sent < RANDOM_PAIRS) begin
      noisy = ($urandom_range(0, 99) < 15);
      len   = ($urandom_range(0, 19) == 0) ? 40 : int'($urandom_range(1, 12));
      for (int k = 0; k < len; k++) begin
        ax = pick_coord();
        ay = pick_coord();
        if ($urandom_range(0, 9) == 0) begin
          send_pair(ax, ay, ax, ay,
                    noisy ? ($urandom_range(0, 3) == 0) : (k == 0),
                    noisy ? ($urandom_range(0, 3) == 0) : (k == len - 1));
        end else begin
          send_pair(ax, ay, pick_coord(), pick_coord(),
                    noisy ? ($urandom_range(0, 3) == 0) : (k == 0),
                    noisy ? ($urandom_range(0, 3) == 0) : (k == len - 1));
        end
        sent++;
      end
    end
    // close whatever frame is still open
    send_pair(pick_coord(), pick_coord(), pick_coord(), pick_coord(), 1'b0, 1'b1);
    in_valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (CORDIC_STAGES + 10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
